[rtl/kts_pkg.sv]
// Package for the keyframe track sampler: payload structs, codes, states.
// Used by kts_divider and keyframe_track_sampler in rtl/, and by the bench.
`timescale 1ns / 1ps
package kts_pkg;

  localparam int unsigned MaxKeys  = 256;
  localparam int unsigned FracBits = 16;
  localparam int unsigned AddrW    = $clog2(MaxKeys);
  localparam int unsigned CountW   = AddrW + 1;

  typedef enum logic [1:0] {
    RS_INTERIOR = 2'd0,
    RS_BEFORE   = 2'd1,
    RS_AFTER    = 2'd2,
    RS_EMPTY    = 2'd3
  } range_status_e;

  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef enum logic {
    CFG_KEY_COUNT = 1'b0,
    CFG_STEP_MODE = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH_RD,
    ST_SEARCH_CMP,
    ST_RD_LEFT,
    ST_RD_RIGHT,
    ST_DIVIDE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  key_slot;
    logic [31:0] key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0] query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [7:0]  left_key;
    logic [1:0]  range_status;
  } out_item_t;

  // Handshake between sequencer and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

[rtl/kts_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module kts_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[rtl/kts_divider.sv]
// Restoring divider for the interpolation factor: one quotient bit a cycle.
// Depends on kts_pkg.
`timescale 1ns / 1ps
module kts_divider import kts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output div_ctl_t    ctl_o,
  output logic [FracBits:0] alpha_o
);
  localparam int unsigned QW = FracBits + 1;
  localparam int unsigned CntW = $clog2(QW + 1);

  logic [32:0]     rem_q, rem_d;
  logic [31:0]     den_q, den_d;
  logic [QW-1:0]   quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [33:0]     trial;

  // Num < den in use, so FracBits steps give (num << FracBits) / den; clamp to 1.0
  always_comb begin
    rem_d = rem_q; den_d = den_q; quo_d = quo_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      rem_d = {1'b0, num_i}; den_d = den_i; quo_d = '0;
      cnt_d = CntW'(FracBits); busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in a zero, trial subtract
      trial = {rem_q, 1'b0} - {2'b00, den_q};
      if (!trial[33]) begin
        rem_d = trial[32:0]; quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], 1'b0}; quo_d = {quo_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; den_q <= den_d; quo_q <= quo_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign alpha_o = (quo_q > QW'(1 << FracBits)) ? QW'(1 << FracBits) : quo_q;
endmodule

[rtl/keyframe_track_sampler.sv]
// Keyframe track sampler top: key tables, search/interpolation sequencer.
// Depends on kts_pkg, kts_ram, kts_divider.
// Each accepted item walks the sequencer: a load writes its slot; a sample ends as empty,
// before first, after last, step interior or linear interior (search, divider, multiply).
// Throughput: one item at a time; the next item is taken once the sequencer is idle again,
// bounded by the single RAM port search, the 16-step divider and output stalls.
// Reset: asynchronous active low; clears key_count, step_mode and control.
`timescale 1ns / 1ps
module keyframe_track_sampler import kts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  state_e state_q, state_d;
  logic [CountW-1:0] count_q;
  logic step_q;
  in_item_t item_q;
  logic [AddrW-1:0] lo_q, lo_d, hi_q, hi_d, addr;
  logic we;
  logic [31:0] rt, rx, ry, rz;
  logic [31:0] t0_q, t0_d;
  logic signed [31:0] x0_q, x0_d, y0_q, y0_d, z0_q, z0_d;
  logic signed [32:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic [31:0] den_q, den_d, num_q, num_d;
  logic div_start;
  logic div_sent_q;
  div_ctl_t div_ctl;
  logic [FracBits:0] alpha;
  out_item_t res_q, res_d;
  out_item_t fin_q, fin_d;
  logic res_v_q, res_v_d;
  logic [CountW-1:0] cnt_eff;
  logic [AddrW-1:0] last_idx;
  logic signed [65:0] prod;
  logic signed [32:0] mul_d;
  logic signed [32:0] mul_b;
  logic [AddrW-1:0] mid;
  logic [AddrW:0] sum;

  assign cnt_eff  = (count_q > CountW'(MaxKeys)) ? CountW'(MaxKeys) : count_q;
  assign last_idx = AddrW'(cnt_eff - 1'b1);
  assign sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = sum[AddrW:1];

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; step_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_COUNT: count_q <= cfg_data_i;
        CFG_STEP_MODE: step_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kts_ram #(.Width(32), .Depth(MaxKeys)) u_t (.clk_i, .we_i(we), .addr_i(addr),
    .wdata_i(item_q.key_time), .rdata_o(rt));
  kts_ram #(.Width(32), .Depth(MaxKeys)) u_x (.clk_i, .we_i(we), .addr_i(addr),
    .wdata_i(item_q.key_x), .rdata_o(rx));
  kts_ram #(.Width(32), .Depth(MaxKeys)) u_y (.clk_i, .we_i(we), .addr_i(addr),
    .wdata_i(item_q.key_y), .rdata_o(ry));
  kts_ram #(.Width(32), .Depth(MaxKeys)) u_z (.clk_i, .we_i(we), .addr_i(addr),
    .wdata_i(item_q.key_z), .rdata_o(rz));

  kts_divider u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(num_q),
    .den_i(den_q), .ctl_o(div_ctl), .alpha_o(alpha));

  // Shared multiplier: one component per cycle
  always_comb begin
    unique case (state_q)
      ST_MUL_Y: mul_d = dy_q;
      ST_MUL_Z: mul_d = dz_q;
      default:  mul_d = dx_q;
    endcase
    mul_b = {16'(0), alpha};
    prod = 66'(mul_d) * 66'(mul_b);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = res_v_q;
  assign out_data_o = res_q;

  // Sequencer
  always_comb begin
    state_d = state_q; lo_d = lo_q; hi_d = hi_q; addr = item_q.key_slot;
    we = 1'b0; t0_d = t0_q; x0_d = x0_q; y0_d = y0_q; z0_d = z0_q;
    dx_d = dx_q; dy_d = dy_q; dz_d = dz_q; num_d = num_q; den_d = den_q;
    div_start = 1'b0; res_d = res_q; fin_d = fin_q; res_v_d = res_v_q;
    if (res_v_q && !out_stall_i) res_v_d = 1'b0;
    unique case (state_q)
      ST_IDLE: ;
      ST_RD_FIRST: begin
        if (item_q.func == FUNC_LOAD) begin
          we = 1'b1; state_d = ST_IDLE;
        end else if (cnt_eff == '0) begin
          fin_d = '{out_x: '0, out_y: '0, out_z: '0, left_key: '0,
                    range_status: RS_EMPTY};
          state_d = ST_OUT;
        end else begin
          addr = '0; state_d = ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: begin
        addr = last_idx;
        if (cnt_eff == CountW'(1) || item_q.query_time <= rt) begin
          fin_d = '{out_x: rx, out_y: ry, out_z: rz, left_key: '0,
                    range_status: RS_BEFORE};
          state_d = ST_OUT;
        end else begin
          state_d = ST_CHK_LAST;
        end
      end
      ST_CHK_LAST: begin
        if (item_q.query_time >= rt) begin
          fin_d = '{out_x: rx, out_y: ry, out_z: rz, left_key: 8'(last_idx),
                    range_status: RS_AFTER};
          state_d = ST_OUT;
        end else begin
          lo_d = '0; hi_d = last_idx; state_d = ST_SEARCH_RD;
        end
      end
      ST_SEARCH_RD: begin
        addr = mid;
        if (AddrW'(lo_q + 1'b1) == hi_q) begin
          addr = lo_q; state_d = ST_RD_LEFT;
        end else begin
          state_d = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: begin
        if (rt <= item_q.query_time) lo_d = mid; else hi_d = mid;
        state_d = ST_SEARCH_RD;
      end
      ST_RD_LEFT: begin
        addr = hi_q;
        t0_d = rt; x0_d = rx; y0_d = ry; z0_d = rz;
        if (step_q) begin
          fin_d = '{out_x: rx, out_y: ry, out_z: rz, left_key: 8'(lo_q),
                    range_status: RS_INTERIOR};
          state_d = ST_OUT;
        end else begin
          state_d = ST_RD_RIGHT;
        end
      end
      ST_RD_RIGHT: begin
        // Differences need one extra bit
        dx_d = {rx[31], rx} - {x0_q[31], x0_q};
        dy_d = {ry[31], ry} - {y0_q[31], y0_q};
        dz_d = {rz[31], rz} - {z0_q[31], z0_q};
        num_d = (item_q.query_time > t0_q) ? item_q.query_time - t0_q : '0;
        den_d = (rt > t0_q) ? rt - t0_q : 32'd1;
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (!div_sent_q && !div_ctl.busy) div_start = 1'b1;
        if (div_ctl.done) state_d = ST_MUL_X;
      end
      ST_MUL_X: begin
        dx_d = 33'(x0_q + 32'(prod >>> FracBits)); state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        dy_d = 33'(y0_q + 32'(prod >>> FracBits)); state_d = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        dz_d = 33'(z0_q + 32'(prod >>> FracBits)); state_d = ST_DONE;
      end
      ST_DONE: begin
        fin_d = '{out_x: dx_q[31:0], out_y: dy_q[31:0], out_z: dz_q[31:0],
                  left_key: 8'(lo_q), range_status: RS_INTERIOR};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Move the finished beat out once the output register is free
        if (!res_v_d) begin
          res_d = fin_q; res_v_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Divider start is a one-cycle pulse; track it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; res_v_q <= 1'b0; div_sent_q <= 1'b0;
    end else begin
      res_v_q <= res_v_d;
      div_sent_q <= (state_q == ST_DIVIDE) && (div_start || div_sent_q);
      if (state_q == ST_IDLE && in_valid_i) state_q <= ST_RD_FIRST;
      else state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) item_q <= in_data_i;
    lo_q <= lo_d; hi_q <= hi_d; t0_q <= t0_d;
    x0_q <= x0_d; y0_q <= y0_d; z0_q <= z0_d;
    dx_q <= dx_d; dy_q <= dy_d; dz_q <= dz_d;
    num_q <= num_d; den_q <= den_d; res_q <= res_d; fin_q <= fin_d;
  end

  // Checks on sequencer behavior
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH_CMP) |-> (lo_q < hi_q)) else $error("bad bracket");
  a_div_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sent_q) else $error("divider restarted");
endmodule

[bench/keyframe_track_sampler_tb.sv]
// Testbench for keyframe_track_sampler: directed table plus random key loads and samples.
// Depends on kts_pkg and the keyframe_track_sampler RTL; checks results with a predictor.
`timescale 1ns / 1ps
module keyframe_track_sampler_tb;
  import kts_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [8:0] cfg_data_i = '0;

  keyframe_track_sampler dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the key table and registers
  logic [31:0] key_times [MaxKeys];
  logic [31:0] key_xs [MaxKeys];
  logic [31:0] key_ys [MaxKeys];
  logic [31:0] key_zs [MaxKeys];
  logic [8:0] track_len;
  logic hold_left;

  out_item_t pending_samples[$];
  int unsigned mismatches = 0;
  int unsigned samples_seen = 0;
  int unsigned loads_sent = 0;
  int unsigned samples_sent = 0;

  // Interpolate one component: v0 + floor((v1 - v0) * alpha / 2^16)
  function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint unsigned alpha);
    longint v0;
    longint prod;
    v0 = longint'($signed(a));
    prod = (longint'($signed(b)) - v0) * longint'(alpha);
    return 32'(v0 + (prod >>> FracBits));
  endfunction

  function automatic out_item_t sample_track(logic [31:0] t);
    out_item_t r;
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    longint unsigned num;
    longint unsigned den;
    longint unsigned alpha;
    r = '0;
    n = (track_len > MaxKeys) ? MaxKeys : track_len;
    if (n == 0) begin
      r.range_status = RS_EMPTY;
    end else if (n == 1 || t <= key_times[0]) begin
      r = '{key_xs[0], key_ys[0], key_zs[0], 8'd0, RS_BEFORE};
    end else if (t >= key_times[n-1]) begin
      r = '{key_xs[n-1], key_ys[n-1], key_zs[n-1], 8'(n - 1), RS_AFTER};
    end else begin
      lo = 0;
      hi = n - 1;
      while (lo + 1 < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_times[mid] <= t) lo = mid;
        else hi = mid;
      end
      r.left_key = 8'(lo);
      r.range_status = RS_INTERIOR;
      if (hold_left) begin
        r.out_x = key_xs[lo];
        r.out_y = key_ys[lo];
        r.out_z = key_zs[lo];
      end else begin
        num = (t > key_times[lo]) ? longint'(t - key_times[lo]) : 0;
        den = (key_times[lo+1] > key_times[lo]) ? longint'(key_times[lo+1] - key_times[lo]) : 1;
        alpha = (num << FracBits) / den;
        if (alpha > (64'd1 << FracBits)) alpha = 64'd1 << FracBits;
        r.out_x = blend(key_xs[lo], key_xs[lo+1], alpha);
        r.out_y = blend(key_ys[lo], key_ys[lo+1], alpha);
        r.out_z = blend(key_zs[lo], key_zs[lo+1], alpha);
      end
    end
    return r;
  endfunction

  task automatic idle_cycles(int unsigned n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_KEY_COUNT) track_len = val;
    else hold_left = val[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Send one beat; when a fixed answer is given it replaces the prediction
  task automatic send_item(in_item_t it, bit has_fixed, out_item_t fixed);
    out_item_t predicted;
    if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 16));
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (it.func == FUNC_LOAD) begin
      key_times[it.key_slot] = it.key_time;
      key_xs[it.key_slot] = it.key_x;
      key_ys[it.key_slot] = it.key_y;
      key_zs[it.key_slot] = it.key_z;
      loads_sent++;
    end else begin
      predicted = sample_track(it.query_time);
      if (has_fixed && predicted != fixed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("directed row disagrees with predictor: %h vs %h", fixed, predicted);
      end
      pending_samples.push_back(has_fixed ? fixed : predicted);
      samples_sent++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drain();
    while (pending_samples.size() != 0) @(negedge clk_i);
    idle_cycles(40);
  endtask

  // Receiver: draw a stall length per beat, then take the beat
  initial begin
    int unsigned gap;
    forever begin
      gap = $urandom_range(0, 16);
      out_stall_i <= 1'b1;
      repeat (gap) @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      samples_seen++;
      if (pending_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample beat %h", out_data_o);
      end else begin
        want = pending_samples.pop_front();
        if (out_data_o.out_x !== want.out_x || out_data_o.out_y !== want.out_y ||
            out_data_o.out_z !== want.out_z || out_data_o.left_key !== want.left_key ||
            out_data_o.range_status !== want.range_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: exp x=%h y=%h z=%h k=%0d s=%0d %s",
                     want.out_x, want.out_y, want.out_z, want.left_key, want.range_status,
                     $sformatf("got x=%h y=%h z=%h k=%0d s=%0d",
                               out_data_o.out_x, out_data_o.out_y, out_data_o.out_z,
                               out_data_o.left_key, out_data_o.range_status));
        end
      end
    end
  end

  initial begin
    #30ms;
    $display("FAIL keyframe_track_sampler");
    $finish;
  end

  function automatic in_item_t load_beat(int slot, logic [31:0] t, logic [31:0] x,
                                        logic [31:0] y, logic [31:0] z);
    in_item_t it;
    it = '{FUNC_LOAD, 8'(slot), t, x, y, z, 32'($urandom())};
    return it;
  endfunction

  function automatic in_item_t sample_beat(logic [31:0] t);
    in_item_t it;
    it = '{FUNC_SAMPLE, 8'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), t};
    return it;
  endfunction

  typedef struct {
    in_item_t beat;
    bit has_fixed;
    out_item_t fixed;
  } row_t;

  row_t rows[$];
  out_item_t none;

  // Load a random track of n keys into slots 0..n-1, each time up to span after the last
  task automatic load_track(int unsigned n, int unsigned span);
    logic [31:0] t;
    t = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(0, 1000);
    for (int unsigned i = 0; i < n; i++) begin
      send_item(load_beat(i, t, $urandom(), $urandom(), $urandom()), 1'b0, none);
      if ($urandom_range(0, 5) != 0) t = t + $urandom_range(0, span);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned span;
    logic [31:0] q;
    none = '0;
    track_len = '0;
    hold_left = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, zero-length and saturating intervals
    rows.push_back('{sample_beat(32'hFFFF_FFFF), 1'b1, '{0, 0, 0, 8'd0, RS_EMPTY}});
    rows.push_back('{load_beat(0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0), 1'b0, none});
    rows.push_back('{load_beat(1, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'hFFFF_FFFF), 1'b0, none});
    rows.push_back('{load_beat(2, 32'h0001_0000, 32'h0, 32'h1, 32'h0001_0000), 1'b0, none});
    rows.push_back('{load_beat(3, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_0000, 32'h5),
                     1'b0, none});
    foreach (rows[i]) send_item(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
    rows.delete();
    wait_drain();
    write_reg(CFG_KEY_COUNT, 9'd1);
    send_item(sample_beat(32'h8000_0000), 1'b1,
              '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 8'd0, RS_BEFORE});
    wait_drain();
    write_reg(CFG_KEY_COUNT, 9'd4);
    rows.push_back('{sample_beat(32'd0), 1'b1,
                     '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 8'd0, RS_BEFORE}});
    rows.push_back('{sample_beat(32'hFFFF_FFFF), 1'b1,
                     '{32'h1234_5678, 32'hFFFF_0000, 32'h5, 8'd3, RS_AFTER}});
    rows.push_back('{sample_beat(32'h0000_8000), 1'b0, none});
    rows.push_back('{sample_beat(32'h0000_0001), 1'b0, none});
    rows.push_back('{sample_beat(32'h0000_FFFF), 1'b0, none});
    rows.push_back('{sample_beat(32'h0001_0000), 1'b0, none});
    rows.push_back('{sample_beat(32'hFFFF_FFFE), 1'b0, none});
    rows.push_back('{sample_beat(32'h8000_0000), 1'b0, none});
    foreach (rows[i]) send_item(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
    wait_drain();
    write_reg(CFG_STEP_MODE, 1'b1);
    foreach (rows[i]) send_item(rows[i].beat, 1'b0, none);
    wait_drain();
    // Out-of-order times exercise the unsorted path
    send_item(load_beat(1, 32'h0000_0100, 32'h7, 32'h8, 32'h9), 1'b0, none);
    send_item(load_beat(2, 32'h0000_0080, 32'hA, 32'hB, 32'hC), 1'b0, none);
    write_reg(CFG_STEP_MODE, 1'b0);
    send_item(sample_beat(32'h0000_00C0), 1'b0, none);
    send_item(sample_beat(32'h0000_0090), 1'b0, none);
    wait_drain();

    // Random phases: a new track and settings, then samples, mostly over its time span
    while (loads_sent + samples_sent < 1550) begin
      case ($urandom_range(0, 5))
        0: n = 256;
        1: n = $urandom_range(1, 3);
        default: n = $urandom_range(2, 24);
      endcase
      span = ($urandom_range(0, 4) == 0) ? 32'h0400_0000 : $urandom_range(1, 32'h0002_0000);
      load_track(n, span);
      write_reg(CFG_KEY_COUNT, ($urandom_range(0, 9) == 0) ? 9'd0 : 9'(n));
      write_reg(CFG_STEP_MODE, 1'($urandom()));
      repeat ((n == 256) ? 40 : $urandom_range(8, 30)) begin
        case ($urandom_range(0, 9))
          0: q = $urandom();
          1: q = key_times[$urandom_range(0, n - 1)];
          default: q = key_times[0] +
                       32'($urandom_range(0, 32'(key_times[n-1] - key_times[0]) + 1));
        endcase
        if ($urandom_range(0, 15) == 0 && n > 1)
          // Rewrite one valid key in place; keep order loosely
          send_item(load_beat($urandom_range(0, n - 1), q, $urandom(), $urandom(), $urandom()),
                    1'b0, none);
        else
          send_item(sample_beat(q), 1'b0, none);
      end
      wait_drain();
    end

    $display("Covered %0d key loads and %0d samples, %0d sample beats checked.",
             loads_sent, samples_sent, samples_seen);
    if (mismatches == 0 && pending_samples.size() == 0) begin
      $display("PASS keyframe_track_sampler");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL keyframe_track_sampler");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/kts_pkg.sv
rtl/kts_ram.sv
rtl/kts_divider.sv
rtl/keyframe_track_sampler.sv
bench/keyframe_track_sampler_tb.sv
